@@ design/lpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the longest prefix route lookup engine.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int ROUTE_COUNT_W = 11;
  localparam int IN_INDEX_W    = 10;
  localparam int ADDR_W        = 32;
  localparam int PORT_W        = 4;
  localparam int S_DATA_W      = 144;
  localparam int M_DATA_W      = 40;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } mem_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] hop_addr;
    logic [PORT_W-1:0] port;
  } result_t;

endpackage

@@ design/lpr_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_table
// Route entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpr_table
  import lpr_pkg::*;
(
  input  logic    clk,
  input  mem_wr_t wr,
  input  mem_rd_t rd,
  output entry_t  rd_data
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

@@ design/lpr_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_scan
// Lookup sequencer: walks the loaded entries one per cycle through a single
// masked compare and keeps the best match, then holds the result beat.
// ----------------------------------------------------------------------------
module lpr_scan
  import lpr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dest_addr,
  input  logic [CNT_W-1:0]  limit,
  output logic              idle,
  output mem_rd_t           rd,
  input  entry_t            rd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  scan_limit;
  logic [ADDR_W-1:0] addr;
  logic              pend;
  logic              hit;
  logic [ADDR_W-1:0] best_mask;
  logic [ADDR_W-1:0] best_hop;
  logic [PORT_W-1:0] best_port;
  logic              issue;
  logic              match;
  logic              take;
  logic              load_out;

  assign idle     = (state == ST_IDLE);
  assign issue    = (state == ST_SCAN) && (rd_ptr < scan_limit);
  assign rd.en    = issue;
  assign rd.addr  = rd_ptr[IDX_W-1:0];
  assign match    = pend && (rd_data.prefix == (addr & rd_data.mask));
  // Only a strictly larger mask replaces the winner, so the lowest slot wins ties.
  assign take     = match && (!hit || (rd_data.mask > best_mask));
  assign load_out = (state == ST_DONE) && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      hit       <= 1'b0;
      res_valid <= 1'b0;
      rd_ptr    <= '0;
    end else begin
      pend <= issue;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state  <= ST_SCAN;
            rd_ptr <= '0;
            hit    <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_ptr <= rd_ptr + CNT_W'(1);
          end
          if (take) begin
            hit <= 1'b1;
          end
          if (!issue && !pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (idle && start) begin
      addr       <= dest_addr;
      scan_limit <= limit;
    end
    if (take) begin
      best_mask <= rd_data.mask;
      best_hop  <= rd_data.hop;
      best_port <= rd_data.port;
    end
    if (load_out) begin
      res.found    <= hit;
      res.hop_addr <= hit ? best_hop : '0;
      res.port     <= hit ? best_port : '0;
    end
  end

endmodule

@@ design/longest_prefix_route_lookup.sv @@
`timescale 1ns / 1ps
// A write beat is stored in the cycle it is accepted.
// A lookup beat scans min(route_count, TABLE_DEPTH) route entries, reading one route entry
// per cycle from the table memory, and then loads its result beat. The input is not ready
// while a lookup scans, nor while a finished lookup waits for the previous result beat to
// be taken.
// Reset clears route_count and empties the result register; the table contents are kept.
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// IPv4 route table with longest prefix match lookup over the loaded entries.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup
  import lpr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // entry_index[9:0], entry_prefix[41:10], entry_mask[73:42],
  // entry_hop_addr[105:74], entry_port[109:106], dest_addr[141:110], zeros above
  input  logic [S_DATA_W-1:0]      s_tdata,
  // func
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // hop_addr[31:0], out_port[35:32], zeros above
  output logic [M_DATA_W-1:0]      m_tdata,
  // found
  output logic                     m_tuser,
  input  logic                     cfg_we,
  input  logic [ROUTE_COUNT_W-1:0] cfg_wdata
);

  logic [ROUTE_COUNT_W-1:0] route_count;
  logic [CNT_W-1:0]         limit;
  logic                     idle;
  logic                     beat;
  logic [IN_INDEX_W-1:0]    entry_index;
  mem_wr_t                  wr;
  mem_rd_t                  rd;
  entry_t                   rd_data;
  result_t                  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
    end else if (cfg_we) begin
      route_count <= cfg_wdata;
    end
  end

  // Counts beyond the table scan the whole table.
  assign limit = (32'(route_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(route_count);

  assign s_tready    = idle;
  assign beat        = s_tvalid && s_tready;
  assign entry_index = s_tdata[9:0];

  assign wr.en          = beat && (s_tuser == FUNC_WRITE)
                          && (32'(entry_index) < 32'(TABLE_DEPTH));
  assign wr.addr        = IDX_W'(entry_index);
  assign wr.entry.prefix = s_tdata[41:10];
  assign wr.entry.mask   = s_tdata[73:42];
  assign wr.entry.hop    = s_tdata[105:74];
  assign wr.entry.port   = s_tdata[109:106];

  lpr_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd      (rd),
    .rd_data (rd_data)
  );

  lpr_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (beat && (s_tuser == FUNC_LOOKUP)),
    .dest_addr (s_tdata[141:110]),
    .limit     (limit),
    .idle      (idle),
    .rd        (rd),
    .rd_data   (rd_data),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {{(M_DATA_W - ADDR_W - PORT_W){1'b0}}, res.port, res.hop_addr};
  assign m_tuser = res.found;

endmodule

@@ design/lpr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_checker
// Port-level checks for the route lookup engine, bound to the top level.
// ----------------------------------------------------------------------------
module lpr_checker
  import lpr_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     s_tuser,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [M_DATA_W-1:0]      m_tdata,
  input logic                     m_tuser
);

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // A miss reports zero next hop and port.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss with nonzero payload");

  // A lookup occupies the engine, so the input closes right after it.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == FUNC_LOOKUP) |=> !s_tready)
    else $error("input ready during a scan");

  // A write beat leaves the engine free and makes no result.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == FUNC_WRITE) && !m_tvalid |=> s_tready && !m_tvalid)
    else $error("write beat disturbed the engine");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind longest_prefix_route_lookup lpr_checker u_lpr_checker (.*);

@@ tb/sv/longest_prefix_route_lookup_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_tb
// Self-checking bench for the route lookup engine. Route writes and lookups
// are streamed in while a shadow copy of the table predicts the winning route
// of every lookup. Results are compared field by field as they come out, under
// several sender and receiver idle mixes and many route count settings.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_tb;
  import lpr_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int LOADED_SLOTS = 64;

  typedef struct {
    logic                  func;
    logic [IN_INDEX_W-1:0] index;
    logic [ADDR_W-1:0]     prefix;
    logic [ADDR_W-1:0]     mask;
    logic [ADDR_W-1:0]     hop;
    logic [PORT_W-1:0]     port;
    logic [ADDR_W-1:0]     dest;
  } route_beat_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [S_DATA_W-1:0]      s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [M_DATA_W-1:0]      m_tdata;
  logic                     m_tuser;
  logic                     cfg_we = 1'b0;
  logic [ROUTE_COUNT_W-1:0] cfg_wdata = '0;

  // Shadow copy of the route table and of route_count.
  logic [ADDR_W-1:0] shadow_prefix [TABLE_DEPTH];
  logic [ADDR_W-1:0] shadow_mask [TABLE_DEPTH];
  logic [ADDR_W-1:0] shadow_hop [TABLE_DEPTH];
  logic [PORT_W-1:0] shadow_port [TABLE_DEPTH];
  bit                shadow_written [TABLE_DEPTH];
  int unsigned       shadow_route_count = 0;
  // Length of the run of written slots that starts at slot 0.
  int unsigned       loaded_slots = 0;

  result_t expected_routes[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int lookup_count = 0;
  int routed_count = 0;
  int write_count = 0;
  int count_settings = 0;

  always #1 clk = ~clk;

  longest_prefix_route_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycle_count,
               expected_routes.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_routes.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("Result beat with no lookup pending: found=%0b hop=%h port=%0d",
                   m_tuser, m_tdata[31:0], m_tdata[35:32]);
        end
        mismatch_count++;
      end else begin
        want = expected_routes.pop_front();
        if (m_tuser !== want.found || m_tdata[31:0] !== want.hop_addr ||
            m_tdata[35:32] !== want.port) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("Route mismatch at cycle %0d: found %0b/%0b hop %h/%h port %0d/%0d",
                     cycle_count, want.found, m_tuser, want.hop_addr, m_tdata[31:0],
                     want.port, m_tdata[35:32]);
            $display("  (values given as expected/actual)");
          end
          mismatch_count++;
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  function automatic int unsigned scan_limit();
    return (shadow_route_count > TABLE_DEPTH) ? TABLE_DEPTH : shadow_route_count;
  endfunction

  // Longest mask wins; a strictly greater mask is needed to displace an
  // earlier match, so the lowest slot wins a tie.
  function automatic result_t predict_route(logic [ADDR_W-1:0] addr);
    result_t           r;
    logic [ADDR_W-1:0] best_mask;
    r = '0;
    best_mask = '0;
    for (int i = 0; i < scan_limit(); i++) begin
      if (shadow_prefix[i] == (addr & shadow_mask[i]) &&
          (!r.found || shadow_mask[i] > best_mask)) begin
        r.found = 1'b1;
        best_mask = shadow_mask[i];
        r.hop_addr = shadow_hop[i];
        r.port = shadow_port[i];
      end
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] len_mask(int unsigned len);
    if (len == 0) return '0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic logic [ADDR_W-1:0] network_base(int unsigned k);
    case (k)
      0: return 32'h0A00_0000;
      1: return 32'hC0A8_0000;
      2: return 32'hAC10_0000;
      default: return 32'h0A01_0200;
    endcase
  endfunction

  // A few common prefix lengths so that equal masks, and thus ties, are frequent.
  function automatic int unsigned common_len();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 8;
      2: return 16;
      3: return 24;
      4: return 32;
      default: return 12;
    endcase
  endfunction

  function automatic route_beat_t write_beat(int unsigned idx, logic [ADDR_W-1:0] pfx,
                                            logic [ADDR_W-1:0] msk, logic [ADDR_W-1:0] hop,
                                            logic [PORT_W-1:0] port);
    route_beat_t b;
    b.func = FUNC_WRITE;
    b.index = idx[IN_INDEX_W-1:0];
    b.prefix = pfx;
    b.mask = msk;
    b.hop = hop;
    b.port = port;
    b.dest = $urandom();
    return b;
  endfunction

  function automatic route_beat_t lookup_beat(logic [ADDR_W-1:0] addr);
    route_beat_t b;
    b.func = FUNC_LOOKUP;
    b.index = IN_INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
    b.prefix = $urandom();
    b.mask = $urandom();
    b.hop = $urandom();
    b.port = PORT_W'($urandom_range(0, 15));
    b.dest = addr;
    return b;
  endfunction

  function automatic route_beat_t random_write(int unsigned idx);
    int unsigned       pick;
    logic [ADDR_W-1:0] msk;
    logic [ADDR_W-1:0] pfx;
    pick = $urandom_range(0, 99);
    if (pick < 70) msk = len_mask(common_len());
    else if (pick < 90) msk = $urandom();
    else msk = len_mask($urandom_range(0, 32));
    // Some prefixes carry bits outside their mask and can never match.
    if ($urandom_range(0, 99) < 80) pfx = network_base($urandom_range(0, 3)) & msk;
    else pfx = $urandom();
    return write_beat(idx, pfx, msk, $urandom(), PORT_W'($urandom_range(0, 15)));
  endfunction

  function automatic route_beat_t random_lookup();
    int unsigned       pick;
    int unsigned       slot;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (scan_limit() > 0 && pick < 70) begin
      slot = $urandom_range(0, scan_limit() - 1);
      addr = shadow_prefix[slot] | ($urandom() & ~shadow_mask[slot]);
    end else if (pick < 85) begin
      addr = network_base($urandom_range(0, 3)) | $urandom_range(0, 255);
    end else begin
      addr = $urandom();
    end
    return lookup_beat(addr);
  endfunction

  task automatic send_beat(route_beat_t b);
    result_t want;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= b.func;
    s_tdata <= {2'b00, b.dest, b.port, b.hop, b.mask, b.prefix, b.index};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (b.func == FUNC_WRITE) begin
      shadow_prefix[b.index] = b.prefix;
      shadow_mask[b.index] = b.mask;
      shadow_hop[b.index] = b.hop;
      shadow_port[b.index] = b.port;
      shadow_written[b.index] = 1'b1;
      while (loaded_slots < TABLE_DEPTH && shadow_written[loaded_slots]) loaded_slots++;
      write_count++;
    end else begin
      want = predict_route(b.dest);
      expected_routes.push_back(want);
      lookup_count++;
      if (want.found) routed_count++;
    end
  endtask

  // Hold the input idle until every pending lookup has produced its result.
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_route_count(int unsigned value);
    wait_results_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value[ROUTE_COUNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_route_count = value;
    count_settings++;
  endtask

  task automatic test_empty_table();
    set_route_count(0);
    send_beat(lookup_beat(32'h0000_0000));
    send_beat(lookup_beat(32'hFFFF_FFFF));
  endtask

  task automatic test_directed_prefixes();
    send_beat(write_beat(0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 4'd15));
    send_beat(write_beat(1, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0001, 4'd1));
    send_beat(write_beat(2, 32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0002, 4'd2));
    send_beat(write_beat(3, 32'h0A01_0203, 32'hFFFF_FFFF, 32'h0000_0003, 4'd3));
    // Same prefix and mask as slot 2; slot 2 must keep winning.
    send_beat(write_beat(4, 32'h0A01_0000, 32'hFFFF_0000, 32'h0000_0004, 4'd4));
    send_beat(write_beat(5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 4'd0));
    // Prefix bit outside a zero mask: this entry never matches.
    send_beat(write_beat(6, 32'h0000_0001, 32'h0000_0000, 32'h1111_1111, 4'd6));
    send_beat(write_beat(7, 32'h0A00_0003, 32'hFF00_00FF, 32'h7777_7777, 4'd7));
    set_route_count(8);
    send_beat(lookup_beat(32'h0A01_0203));
    send_beat(lookup_beat(32'h0A01_0204));
    send_beat(lookup_beat(32'h0A7F_0000));
    send_beat(lookup_beat(32'h0A55_AA03));
    send_beat(lookup_beat(32'h0B00_0000));
    send_beat(lookup_beat(32'hFFFF_FFFF));
    send_beat(lookup_beat(32'h0000_0000));
    set_route_count(1);
    send_beat(lookup_beat(32'h0A01_0203));
    set_route_count(0);
    send_beat(lookup_beat(32'h0A01_0203));
  endtask

  // Load the low slots, then look up with every loaded entry taking part.
  task automatic test_loaded_table();
    for (int i = 8; i < LOADED_SLOTS - 1; i++) send_beat(random_write(i));
    send_beat(write_beat(LOADED_SLOTS - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_5A5A,
                         4'd9));
    set_route_count(LOADED_SLOTS);
    send_beat(lookup_beat(32'hFFFF_FFFF));
    send_beat(random_lookup());
    send_beat(random_lookup());
    send_beat(random_lookup());
  endtask

  // Route counts never exceed the run of slots written from slot 0, so every
  // scanned slot holds a defined entry.
  task automatic test_random_traffic(int src_pct, int sink_pct, int beats);
    int unsigned pick;
    int unsigned burst;
    int unsigned top_slot;
    int unsigned small_top;
    int          sent;
    sent = 0;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    while (sent < beats) begin
      small_top = (loaded_slots > 48) ? 48 : loaded_slots;
      pick = $urandom_range(0, 99);
      if (pick < 85) set_route_count($urandom_range(0, small_top));
      else set_route_count($urandom_range(small_top, loaded_slots));
      burst = $urandom_range(20, 50);
      top_slot = (loaded_slots + 8 > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : loaded_slots + 8;
      for (int k = 0; k < burst && sent < beats; k++) begin
        if ($urandom_range(0, 99) < 5) wait_results_drained();
        if ($urandom_range(0, 1) == 0) begin
          if ($urandom_range(0, 99) < 70) send_beat(random_write($urandom_range(0, top_slot)));
          else send_beat(random_write($urandom_range(0, TABLE_DEPTH - 1)));
        end else begin
          send_beat(random_lookup());
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    src_idle_pct = 20;
    sink_idle_pct = 63;
    test_empty_table();
    test_directed_prefixes();
    test_loaded_table();
    test_random_traffic(20, 63, 170);
    test_random_traffic(63, 20, 170);
    test_random_traffic(0, 0, 160);
    wait_results_drained();
    repeat (scan_limit() + 8) @(posedge clk);
    if (expected_routes.size() != 0) begin
      $display("%0d lookups never produced a result", expected_routes.size());
      mismatch_count += expected_routes.size();
    end
    $display("Ran %0d lookups (%0d routed, %0d without a route) and %0d route writes",
             lookup_count, routed_count, lookup_count - routed_count, write_count);
    $display("over %0d route count settings and three idle mixes in %0d cycles",
             count_settings, cycle_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
